// ----- rtl/core/fhc_pkg.sv -----
package fhc_pkg;

   // operation codes carried by req_operation
   typedef enum logic [1:0] {
      OP_SINGLE_TO_HALF = 2'd0,
      OP_HALF_TO_SINGLE = 2'd1,
      OP_SINGLE_TO_BF16 = 2'd2,
      OP_BF16_TO_SINGLE = 2'd3
   } op_type;

   // what is left to do after decode
   typedef enum logic [1:0] {
      KIND_DONE    = 2'd0,
      KIND_S2H_SUB = 2'd1,
      KIND_H2S_SUB = 2'd2
   } kind_type;

   localparam int WORD_W   = 32;
   localparam int AMOUNT_W = 5;
   localparam int NORM_W   = 4;

   // decode stage -> shift stage
   typedef struct packed {
      kind_type              kind;
      logic [WORD_W-1:0]     word;
      logic [AMOUNT_W-1:0]   amount;
   } dec_type;

   // shift stage -> round stage
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              rnd;
   } shf_type;

   // left shift that brings the top set bit of a half mantissa to the hidden bit
   function automatic logic [NORM_W-1:0] norm_shift(input logic [9:0] mant);
      logic [NORM_W-1:0] sh;
      sh = '0;
      for (int i = 0; i < 10; i++) begin
         if (mant[i]) begin
            sh = NORM_W'(10 - i);
         end
      end
      return sh;
   endfunction

endpackage

// ----- rtl/core/fhc_decode.sv -----
module fhc_decode
   import fhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        valid_in,
   input  logic [1:0]  operation,
   input  logic [31:0] operand_bits,
   output logic        valid_ff,
   output dec_type     dec_ff
);

   dec_type dec_in;
   logic    sgl_sign;
   logic [7:0]  sgl_exp;
   logic [22:0] sgl_mant;
   logic    hlf_sign;
   logic [4:0]  hlf_exp;
   logic [9:0]  hlf_mant;

   assign sgl_sign = operand_bits[31];
   assign sgl_exp  = operand_bits[30:23];
   assign sgl_mant = operand_bits[22:0];
   assign hlf_sign = operand_bits[15];
   assign hlf_exp  = operand_bits[14:10];
   assign hlf_mant = operand_bits[9:0];

   always_comb begin
      dec_in.kind   = KIND_DONE;
      dec_in.word   = '0;
      dec_in.amount = '0;
      unique case (op_type'(operation))
         OP_SINGLE_TO_HALF: begin
            if (sgl_exp == 8'hff) begin
               dec_in.word = {16'b0, sgl_sign, 5'h1f, (sgl_mant != '0), 9'b0};
            end else if (sgl_exp >= 8'd143) begin
               // overflow to signed infinity
               dec_in.word = {16'b0, sgl_sign, 5'h1f, 10'b0};
            end else if (sgl_exp < 8'd102) begin
               // too small even for a half subnormal
               dec_in.word = {16'b0, sgl_sign, 15'b0};
            end else if (sgl_exp <= 8'd112) begin
               dec_in.kind   = KIND_S2H_SUB;
               dec_in.word   = {sgl_sign, 7'b0, 1'b1, sgl_mant};
               dec_in.amount = AMOUNT_W'(8'd126 - sgl_exp);
            end else begin
               dec_in.word = {16'b0, sgl_sign, 5'(sgl_exp - 8'd112), sgl_mant[22:13]};
            end
         end
         OP_HALF_TO_SINGLE: begin
            if (hlf_exp == 5'd0) begin
               if (hlf_mant == '0) begin
                  dec_in.word = {hlf_sign, 31'b0};
               end else begin
                  dec_in.kind   = KIND_H2S_SUB;
                  dec_in.word   = {hlf_sign, 21'b0, hlf_mant};
                  dec_in.amount = AMOUNT_W'(norm_shift(hlf_mant));
               end
            end else if (hlf_exp == 5'h1f) begin
               dec_in.word = {hlf_sign, 8'hff, hlf_mant, 13'b0};
            end else begin
               dec_in.word = {hlf_sign, {3'b0, hlf_exp} + 8'd112, hlf_mant, 13'b0};
            end
         end
         OP_SINGLE_TO_BF16: begin
            dec_in.word = {16'b0, operand_bits[31:16]};
         end
         OP_BF16_TO_SINGLE: begin
            dec_in.word = {operand_bits[15:0], 16'b0};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dec_ff <= dec_in;
      end
   end

endmodule

// ----- rtl/core/fhc_shift.sv -----
module fhc_shift
   import fhc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    enable,
   input  logic    valid_in,
   input  dec_type dec,
   output logic    valid_ff,
   output shf_type shf_ff
);

   shf_type    shf_in;
   logic [23:0] sub_mant;
   logic [10:0] sub_quot;
   logic [9:0]  norm_mant;
   logic [7:0]  norm_exp;

   assign sub_mant  = dec.word[23:0];
   assign sub_quot  = 11'(sub_mant >> dec.amount);
   assign norm_mant = dec.word[9:0] << dec.amount[NORM_W-1:0];
   assign norm_exp  = 8'd113 - {4'b0, dec.amount[NORM_W-1:0]};

   always_comb begin
      shf_in.word = dec.word;
      shf_in.rnd  = 1'b0;
      case (dec.kind)
         KIND_S2H_SUB: begin
            // shifted into the half subnormal range, round half up later
            shf_in.word = {16'b0, dec.word[31], 4'b0, sub_quot};
            shf_in.rnd  = sub_mant[dec.amount - 5'd1];
         end
         KIND_H2S_SUB: begin
            shf_in.word = {dec.word[31], norm_exp, norm_mant, 13'b0};
         end
         default: begin
            shf_in.word = dec.word;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         shf_ff <= shf_in;
      end
   end

endmodule

// ----- rtl/core/fhc_round.sv -----
module fhc_round
   import fhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        valid_in,
   input  shf_type     shf,
   output logic        valid_ff,
   output logic [31:0] result_ff
);

   logic [31:0] result_in;

   // carry out of the subnormal field lands on the smallest normal
   assign result_in = {shf.word[31:16], shf.word[15:0] + {15'b0, shf.rnd}};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

endmodule

// ----- rtl/core/float_half_format_converter_core.sv -----
// Converts raw bit patterns between single precision, half precision and bfloat16,
// chosen per item by req_operation: 0 single to half, 1 half to single, 2 single to
// bfloat16, 3 bfloat16 to single. Half and bfloat16 sources use the low 16 operand
// bits, and 16-bit results come back zero-extended. Single to half truncates normal
// mantissas, rounds half up in the half subnormal range, flushes anything smaller
// (single subnormals too) to signed zero, saturates overflow to signed infinity and
// turns NaN into the quiet half NaN without payload. Half to single is exact and
// keeps NaN payloads. The core is a three-stage pipeline (decode, shift, round) that
// takes one item every cycle while req_stall is low; the result register is the last
// stage, so new items keep flowing in while a result waits, until the earlier stages
// fill, and bubbles are squeezed out when rsp_stall is held.
module float_half_format_converter_core
   import fhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_operand_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_bits
);

   // per-stage advance: a stage loads when its slot is empty or drains onward
   logic    adv_dec;
   logic    adv_shf;
   logic    adv_rnd;

   logic    dec_valid;
   dec_type dec_word;
   logic    shf_valid;
   shf_type shf_word;

   assign adv_rnd   = !rsp_valid || !rsp_stall;
   assign adv_shf   = !shf_valid || adv_rnd;
   assign adv_dec   = !dec_valid || adv_shf;
   assign req_stall = !adv_dec;

   // stage 1: classify the operand and build the result where no shift is needed
   fhc_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .enable       (adv_dec),
      .valid_in     (req_valid),
      .operation    (req_operation),
      .operand_bits (req_operand_bits),
      .valid_ff     (dec_valid),
      .dec_ff       (dec_word)
   );

   // stage 2: subnormal right shift for half output, renormalise for half input
   fhc_shift u_shift (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv_shf),
      .valid_in (dec_valid),
      .dec      (dec_word),
      .valid_ff (shf_valid),
      .shf_ff   (shf_word)
   );

   // stage 3: round-half-up increment into the output register
   fhc_round u_round (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv_rnd),
      .valid_in  (shf_valid),
      .shf       (shf_word),
      .valid_ff  (rsp_valid),
      .result_ff (rsp_result_bits)
   );

`ifndef SYNTHESIS
   // input is only held off when every stage holds an item
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (dec_valid && shf_valid && rsp_valid))
      else $error("input stalled with a free pipeline slot");

   // an accepted item always lands in the decode stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> dec_valid)
      else $error("accepted item lost at decode");

   // a held item in the shift stage is neither dropped nor altered
   a_shift_holds: assert property (@(posedge clock) disable iff (reset)
      (shf_valid && !adv_shf) |=> (shf_valid && $stable(shf_word)))
      else $error("stalled shift stage changed");
`endif

endmodule
